// ===== hw/rtl/dual_quadrature_velocity_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// dual quadrature velocity counter assertion macros
// immediate-implication and next-cycle property wrappers
// ----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_VELOCITY_COUNTER_TOP_ASSERT_SVH
`define DUAL_QUADRATURE_VELOCITY_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define DQV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DQV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DQV_ASSERT_IMP(label, ante, cons)
`define DQV_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/dqv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqv_pkg
// shared constants, types and the velocity saturation function
// ----------------------------------------------------------------------------
package dqv_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SCALE_BITS = 16;
    localparam int VEL_BITS   = 16;
    localparam int FRAC_BITS  = 8;
    localparam int FRAC_MASK  = (1 << FRAC_BITS) - 1;
    // signed count times zero-extended unsigned scale
    localparam int PROD_BITS  = COUNT_BITS + SCALE_BITS + 1;
    localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;

    // 5170 / 256 ~ 20.1953 velocity units per count
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(5170);

    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = ~COUNT_MAX;

    localparam logic signed [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
    localparam logic signed [VEL_BITS-1:0] VEL_MIN = ~VEL_MAX;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } kind_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic signed [PROD_BITS-1:0] product;
        logic                        clip;
    } lane_result_t;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] vel;
        logic                       clip;
    } vel_result_t;

    // divide by 256 toward zero, then clip to the velocity range
    function automatic vel_result_t sat_velocity(input logic signed [PROD_BITS-1:0] prod);
        logic signed [PROD_BITS-1:0] biased;
        logic signed [QUOT_BITS-1:0] quot;
        vel_result_t                 res;
        biased = prod + (prod[PROD_BITS-1] ? PROD_BITS'(FRAC_MASK) : '0);
        quot   = biased[PROD_BITS-1:FRAC_BITS];
        if ((&quot[QUOT_BITS-1:VEL_BITS-1]) || !(|quot[QUOT_BITS-1:VEL_BITS-1]))
        begin
            res.vel  = quot[VEL_BITS-1:0];
            res.clip = 1'b0;
        end
        else
        begin
            res.vel  = quot[QUOT_BITS-1] ? VEL_MIN : VEL_MAX;
            res.clip = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/dual_quadrature_velocity_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_velocity_counter_top
// two-wheel x2 quadrature counter with scaled per-period velocity words
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | kind, left_a, left_b, right_a, right_b
//  out     | out_valid / out_stall| left_velocity, right_velocity, saturated
//  cfg     | cfg_we               | cfg_wdata (velocity scale, Q8.8)
//
//  one input word per cycle while in_stall is low; sample words produce nothing, tick
//  words produce one output word, through the product register and the output register
//  the rate is one word a cycle unless in_stall holds it, set by the per-lane counter update
//  latency is set by the product register in each lane and the output register
//  reset clears counts, clip flags, previous A levels, valid bits; scale to 5170
//  in_stall rises only when a tick product waits and the output word is stalled
//
`include "dual_quadrature_velocity_counter_top_assert.svh"

module dual_quadrature_velocity_counter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic                                left_a,
    input  logic                                left_b,
    input  logic                                right_a,
    input  logic                                right_b,
    // output words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dqv_pkg::VEL_BITS-1:0] left_velocity,
    output logic signed [dqv_pkg::VEL_BITS-1:0] right_velocity,
    output logic                                saturated,
    // configuration
    input  logic                                cfg_we,
    input  logic [dqv_pkg::SCALE_BITS-1:0]      cfg_wdata
);

    logic [dqv_pkg::SCALE_BITS-1:0] scale_reg;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           in_accept;
    logic                           tick_en;
    logic                           sample_en;
    logic                           take;
    dqv_pkg::lane_result_t          left_res, right_res;

    // scale register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= dqv_pkg::SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    // hold input only when the product stage is full and cannot drain
    assign in_stall  = s1_valid_reg && !take;
    assign in_accept = in_valid && !in_stall;
    assign tick_en   = in_accept && (kind == dqv_pkg::KIND_TICK);
    assign sample_en = in_accept && (kind == dqv_pkg::KIND_SAMPLE);

    // product stage valid: set by a tick, cleared when the merge takes it
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_en)
            s1_valid_next = 1'b1;
        else if (take)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // left and right lanes run side by side on the same word
    dqv_lane u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_en),
        .tick_en   (tick_en),
        .a         (left_a),
        .b         (left_b),
        .scale     (scale_reg),
        .result    (left_res)
    );

    dqv_lane u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_en),
        .tick_en   (tick_en),
        .a         (right_a),
        .b         (right_b),
        .scale     (scale_reg),
        .result    (right_res)
    );

    // truncation, clipping and the output word register
    dqv_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid_reg),
        .left_res       (left_res),
        .right_res      (right_res),
        .take           (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_velocity  (left_velocity),
        .right_velocity (right_velocity),
        .saturated      (saturated)
    );

    // an accepted tick always lands in the product stage
    `DQV_ASSERT_NXT(a_tick_loads_s1, tick_en, s1_valid_reg)
    // a pending product is kept while the output is blocked
    `DQV_ASSERT_NXT(a_s1_held, s1_valid_reg && !take, s1_valid_reg)

endmodule

// ===== hw/rtl/dqv_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqv_lane
// one encoder channel: x2 edge counter with clip flag and scale multiply
// ----------------------------------------------------------------------------
`include "dual_quadrature_velocity_counter_top_assert.svh"

module dqv_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_en,
    input  logic                                tick_en,
    input  logic                                a,
    input  logic                                b,
    input  logic [dqv_pkg::SCALE_BITS-1:0]      scale,
    output dqv_pkg::lane_result_t               result
);

    logic                                   prev_a_reg, prev_a_next;
    logic signed [dqv_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic                                   clip_reg, clip_next;
    dqv_pkg::lane_result_t                  result_reg, result_next;
    logic signed [dqv_pkg::SCALE_BITS:0]    scale_s;
    logic                                   edge_seen;

    assign scale_s   = {1'b0, scale};
    assign edge_seen = a != prev_a_reg;

    always_comb
    begin
        prev_a_next = prev_a_reg;
        count_next  = count_reg;
        clip_next   = clip_reg;
        result_next = result_reg;
        if (tick_en)
        begin
            // snapshot into the product stage, then start a new period
            result_next.product = count_reg * scale_s;
            result_next.clip    = clip_reg;
            count_next          = '0;
            clip_next           = 1'b0;
        end
        else if (sample_en)
        begin
            prev_a_next = a;
            if (edge_seen && (a != b))
            begin
                if (count_reg == dqv_pkg::COUNT_MAX)
                    clip_next = 1'b1;
                else
                    count_next = count_reg + 1'b1;
            end
            else if (edge_seen)
            begin
                if (count_reg == dqv_pkg::COUNT_MIN)
                    clip_next = 1'b1;
                else
                    count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg <= 1'b0;
            count_reg  <= '0;
            clip_reg   <= 1'b0;
        end
        else
        begin
            prev_a_reg <= prev_a_next;
            count_reg  <= count_next;
            clip_reg   <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // a tick starts the period from zero
    `DQV_ASSERT_NXT(a_lane_tick_clears, tick_en, (count_reg == '0) && !clip_reg)
    // the count moves by at most one step per sample
    `DQV_ASSERT_NXT(a_lane_single_step, sample_en && !tick_en, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1))

endmodule

// ===== hw/rtl/dqv_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqv_merge
// joins both lanes: truncation toward zero, int16 clipping and the output word register
// ----------------------------------------------------------------------------
module dqv_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s1_valid,
    input  dqv_pkg::lane_result_t               left_res,
    input  dqv_pkg::lane_result_t               right_res,
    output logic                                take,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dqv_pkg::VEL_BITS-1:0] left_velocity,
    output logic signed [dqv_pkg::VEL_BITS-1:0] right_velocity,
    output logic                                saturated
);

    dqv_pkg::vel_result_t                left_sat, right_sat;
    logic                                valid_reg, valid_next;
    logic signed [dqv_pkg::VEL_BITS-1:0] left_reg, left_next;
    logic signed [dqv_pkg::VEL_BITS-1:0] right_reg, right_next;
    logic                                sat_reg, sat_next;

    assign left_sat  = dqv_pkg::sat_velocity(left_res.product);
    assign right_sat = dqv_pkg::sat_velocity(right_res.product);

    // output register free or being emptied this cycle
    assign take = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        left_next  = left_reg;
        right_next = right_reg;
        sat_next   = sat_reg;
        if (take)
        begin
            valid_next = s1_valid;
            if (s1_valid)
            begin
                left_next  = left_sat.vel;
                right_next = right_sat.vel;
                sat_next   = left_sat.clip | right_sat.clip | left_res.clip | right_res.clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        sat_reg   <= sat_next;
    end

    assign out_valid      = valid_reg;
    assign left_velocity  = left_reg;
    assign right_velocity = right_reg;
    assign saturated      = sat_reg;

endmodule
